// ===== sv/lru_key_value_cache_macros.svh =====
// assertion macros shared by the cache rtl
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

// same-cycle implication, clocked on aclk, off during reset
`define LKVC_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off during reset
`define LKVC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/lkvc_pkg.sv =====
// types and constants for the lru key-value cache
package lkvc_pkg;

    // key and value word
    typedef logic signed [31:0] word_t;

    // width of the capacity register
    localparam int CAP_W = 5;

    // capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // value returned on a get miss
    localparam word_t MISS_VALUE = -32'sd1;

    // value returned on a set
    localparam word_t SET_VALUE = 32'sd0;

    // command codes
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_SET = 1'b1;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } state_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic cmp_en;
        logic shift_en;
        logic valid;
    } cell_ctrl_t;

endpackage

// ===== sv/lkvc_cell.sv =====
// one cache slot: key, value and a registered match against the request
module lkvc_cell (
    input  logic                aclk,
    input  lkvc_pkg::cell_ctrl_t ctrl,
    input  lkvc_pkg::word_t     req_key,
    input  lkvc_pkg::word_t     prev_key,
    input  lkvc_pkg::word_t     prev_value,
    output lkvc_pkg::word_t     key_q,
    output lkvc_pkg::word_t     value_q,
    output logic                match_q
);
    import lkvc_pkg::*;

    word_t key_reg;
    word_t value_reg;
    logic  match_reg;

    // compare on request, take neighbour's entry on shift
    always_ff @(posedge aclk) begin
        if (ctrl.cmp_en) begin
            match_reg <= ctrl.valid && (key_reg == req_key);
        end
        if (ctrl.shift_en) begin
            key_reg   <= prev_key;
            value_reg <= prev_value;
        end
    end

    assign key_q   = key_reg;
    assign value_q = value_reg;
    assign match_q = match_reg;

endmodule

// ===== sv/lru_key_value_cache.sv =====
// top level of the lru key-value cache: request sequencer and chain of slots
// Key-value cache of up to DEPTH entries kept in slot cells in order of last
// set, slot 0 the most recent. A beat on the s_ channel is a get (s_cmd 0)
// or a set (s_cmd 1); each gives exactly one beat on the m_ channel: a get
// returns m_hit and the stored value, or m_hit 0 and -1 on a miss, a set
// returns m_hit 0 and 0. Items go through accept, a compare cycle in which
// all cells match the key in parallel, and an update cycle in which the hit
// is encoded and, on a set, the cells up to the hit slot (or the last kept
// slot) shift one place down while slot 0 takes the new entry. A stalled m_
// channel holds the update cycle. The user must write the capacity register
// (1 to DEPTH, 0 reads as 1) through cfg_wr_en / cfg_wr_data only while no
// item is in flight; the block does not enforce this. Lowering it drops the
// least recent entries at once. There is no clearing pass after reset.
`include "lru_key_value_cache_macros.svh"

module lru_key_value_cache #(
    parameter int DEPTH = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [lkvc_pkg::CAP_W-1:0] cfg_wr_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_cmd,
    input  lkvc_pkg::word_t            s_key,
    input  lkvc_pkg::word_t            s_data_in,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_hit,
    output lkvc_pkg::word_t            m_data_out
);
    import lkvc_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int CNT_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

    // effective capacity, clamped to 1..DEPTH
    function automatic logic [CNT_W-1:0] eff_cap_f(input logic [CAP_W-1:0] c);
        logic [CNT_W-1:0] w;
        w = CNT_W'(c);
        if (w == '0) w = CNT_W'(1);
        if (w > CNT_W'(DEPTH)) w = CNT_W'(DEPTH);
        return w;
    endfunction

    state_t               state_reg, state_next;
    logic [CAP_W-1:0]     capacity_reg;
    logic [OCC_W-1:0]     occupancy_reg;
    logic                 req_cmd_reg;
    word_t                req_key_reg;
    word_t                req_data_reg;
    logic                 m_valid_reg;
    logic                 m_hit_reg;
    word_t                m_data_reg;

    logic                 cmp_en;
    logic                 adv;
    logic [CNT_W-1:0]     eff_cap;
    logic [CNT_W-1:0]     cfg_cap;
    logic [OCC_W-1:0]     miss_last;
    logic [IDX_W-1:0]     found_idx;
    logic [IDX_W-1:0]     limit;
    logic                 hit_any;
    word_t                hit_value;

    cell_ctrl_t           ctrl  [DEPTH];
    word_t                key_q [DEPTH];
    word_t                val_q [DEPTH];
    logic [DEPTH-1:0]     match;

    assign eff_cap = eff_cap_f(capacity_reg);
    assign cfg_cap = eff_cap_f(cfg_wr_data);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_CMP;
            ST_CMP:  state_next = ST_UPD;
            ST_UPD:  if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready = 1'b0;
        cmp_en  = 1'b0;
        adv     = 1'b0;
        case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_CMP:  cmp_en  = 1'b1;
            ST_UPD:  adv     = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // request capture
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_cmd_reg  <= s_cmd;
            req_key_reg  <= s_key;
            req_data_reg <= s_data_in;
        end
    end

    // encode the single matching slot and gather its value
    always_comb begin
        found_idx = '0;
        hit_value = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (match[i]) begin
                found_idx = found_idx | IDX_W'(i);
                hit_value = hit_value | val_q[i];
            end
        end
        hit_any = |match;
    end

    // last slot that shifts: the hit slot, or the last kept slot on a miss
    always_comb begin
        if (CNT_W'(occupancy_reg) < eff_cap) begin
            miss_last = occupancy_reg;
        end else begin
            miss_last = OCC_W'(eff_cap - CNT_W'(1));
        end
        limit = hit_any ? found_idx : IDX_W'(miss_last);
    end

    // per-cell control
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            ctrl[i].cmp_en   = cmp_en;
            ctrl[i].valid    = OCC_W'(i) < occupancy_reg;
            ctrl[i].shift_en = adv && (req_cmd_reg == CMD_SET) && (IDX_W'(i) <= limit);
        end
    end

    // chain of slot cells, each fed by its upper neighbour
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            lkvc_cell u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl[g]),
                .req_key    (req_key_reg),
                .prev_key   (req_key_reg),
                .prev_value (req_data_reg),
                .key_q      (key_q[g]),
                .value_q    (val_q[g]),
                .match_q    (match[g])
            );
        end else begin : g_body
            lkvc_cell u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl[g]),
                .req_key    (req_key_reg),
                .prev_key   (key_q[g-1]),
                .prev_value (val_q[g-1]),
                .key_q      (key_q[g]),
                .value_q    (val_q[g]),
                .match_q    (match[g])
            );
        end
    end

    // capacity and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg  <= CAP_RESET;
            occupancy_reg <= '0;
        end else if (adv && (req_cmd_reg == CMD_SET) && !hit_any) begin
            occupancy_reg <= miss_last + OCC_W'(1);
        end else if (cfg_wr_en) begin
            capacity_reg <= cfg_wr_data;
            if (CNT_W'(occupancy_reg) > cfg_cap) begin
                occupancy_reg <= OCC_W'(cfg_cap);
            end
        end
    end

    // result beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (req_cmd_reg == CMD_SET) begin
                m_hit_reg  <= 1'b0;
                m_data_reg <= SET_VALUE;
            end else begin
                m_hit_reg  <= hit_any;
                m_data_reg <= hit_any ? hit_value : MISS_VALUE;
            end
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_hit      = m_hit_reg;
    assign m_data_out = m_data_reg;

    // checks
    `LKVC_ASSERT_NOW(a_occ_within_cap, 1'b1, CNT_W'(occupancy_reg) <= eff_cap, "occupancy above capacity")
    `LKVC_ASSERT_NOW(a_unique_match, state_reg == ST_UPD, $onehot0(match), "key stored in more than one slot")
    `LKVC_ASSERT_NEXT(a_accept_to_cmp, s_valid && s_ready, state_reg == ST_CMP, "accepted beat did not start compare")
    `LKVC_ASSERT_NEXT(a_miss_set_grows, adv && (req_cmd_reg == CMD_SET) && !hit_any && (CNT_W'(occupancy_reg) < eff_cap), occupancy_reg == $past(occupancy_reg) + OCC_W'(1), "insert below capacity did not grow occupancy")

endmodule
